// File: hdl/assert_macros.svh
// Assertion macros included by the store core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition implies a consequence on the same clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/bcss_pkg.sv
// Package with constants and types of the blocked character sequence store.
package bcss_pkg;
	localparam int BlockCap = 64;
	localparam int NumBlocks = 64;
	localparam int OffW = $clog2(BlockCap);
	localparam int BlkW = $clog2(NumBlocks);
	localparam int FillW = $clog2(BlockCap + 1);
	localparam int LinkW = $clog2(NumBlocks + 1);
	localparam int MetaW = FillW + LinkW;
	localparam int PosW = 13;
	localparam int CharW = 8;
	localparam int StatW = 2;
	localparam int AddrW = BlkW + OffW;
	localparam int UsedW = $clog2(NumBlocks + 1);
	localparam logic [LinkW-1:0] LinkEnd = LinkW'(NumBlocks);

	localparam logic CmdInsert = 1'b0;
	localparam logic CmdQuery = 1'b1;
	localparam logic [StatW-1:0] StatOk = 2'd0;
	localparam logic [StatW-1:0] StatRange = 2'd1;
	localparam logic [StatW-1:0] StatFull = 2'd2;

	typedef struct packed {
		logic command;
		logic [PosW-1:0] position;
		logic [CharW-1:0] character;
	} item_t;

	typedef struct packed {
		logic [CharW-1:0] read_char;
		logic [StatW-1:0] status;
		logic [PosW-1:0] seq_length;
	} result_t;
endpackage

// File: hdl/bcss_stream_if.sv
// Valid/ready channel interfaces for items and results.
interface bcss_item_if;
	import bcss_pkg::*;
	logic valid;
	logic ready;
	logic command;
	logic [PosW-1:0] position;
	logic [CharW-1:0] character;
	modport source (output valid, command, position, character, input ready);
	modport sink (input valid, command, position, character, output ready);
endinterface

interface bcss_result_if;
	import bcss_pkg::*;
	logic valid;
	logic ready;
	logic [CharW-1:0] read_char;
	logic [StatW-1:0] status;
	logic [PosW-1:0] seq_length;
	modport source (output valid, read_char, status, seq_length, input ready);
	modport sink (input valid, read_char, status, seq_length, output ready);
endinterface

// File: hdl/blocked_char_sequence_store_core.sv
// An insert walks the chain to its block, shifts the later bytes up one at a time, writes the
// new byte and, when the block fills with a spare block left, moves its upper half to a spare.
// A query walks the chain and reads one byte; a query at zero or past the end skips the walk.
// A dropped insert walks the chain only. One item at a time: the next item is taken only
// after the last result is accepted. Reset: asynchronous; a clearing pass then clears fills
// and links with ready low. The character RAM is not cleared; one block in use, length zero.
module blocked_char_sequence_store_core (
	input logic clk,
	input logic arst_n,
	bcss_item_if.sink in_item,
	bcss_result_if.source out_result
);
	import bcss_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [9:0] {
		ST_CLR   = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_WRD   = 10'b0000000100,
		ST_WALK  = 10'b0000001000,
		ST_DEC   = 10'b0000010000,
		ST_SHRD  = 10'b0000100000,
		ST_SHWR  = 10'b0001000000,
		ST_SPRD  = 10'b0010000000,
		ST_SPWR  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [UsedW-1:0] used_q;
	logic [PosW-1:0] len_q;
	logic [BlkW-1:0] clr_q;

	logic cmd_q;
	logic [PosW-1:0] k_q;
	logic [CharW-1:0] ch_q;
	logic [BlkW-1:0] cur_q;
	logic [BlkW-1:0] fresh_q;
	logic [FillW-1:0] idx_q;
	logic [FillW-1:0] keep_q;
	logic [BlkW:0] steps_q;
	logic [FillW-1:0] cfill_q;
	logic [LinkW-1:0] clink_q;
	logic [CharW-1:0] rd_q;
	logic [StatW-1:0] stat_q;
	logic out_valid_q;

	logic we;
	logic [AddrW-1:0] waddr, raddr;
	logic [CharW-1:0] wdata, rdata;

	logic meta_we;
	logic [BlkW-1:0] meta_waddr;
	logic [MetaW-1:0] meta_wdata, meta_rdata;

	bcss_ram #(.Width(CharW), .Depth(NumBlocks * BlockCap)) u_char_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// fill and link of each block, read at the current block
	bcss_ram #(.Width(MetaW), .Depth(NumBlocks)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata), .raddr(cur_q),
		.rdata(meta_rdata)
	);

	logic [FillW-1:0] m_fill;
	logic [LinkW-1:0] m_link;
	logic walk_more;
	logic split_go;
	logic used_ok;
	logic [PosW-1:0] pos_m1;
	assign m_fill = meta_rdata[MetaW-1:LinkW];
	assign m_link = meta_rdata[LinkW-1:0];
	assign walk_more = (k_q > PosW'(m_fill)) && (m_link < LinkEnd)
		&& (steps_q < (BlkW+1)'(NumBlocks));
	// the insert fills the block and a spare block is left
	assign split_go = (cfill_q == FillW'(BlockCap - 1)) && (used_q < UsedW'(NumBlocks));
	assign used_ok = (used_q >= UsedW'(1)) && (used_q <= UsedW'(NumBlocks));
	assign pos_m1 = in_item.position - PosW'(1);

	assign in_item.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_result.valid = out_valid_q;
	assign out_result.read_char = rd_q;
	assign out_result.status = stat_q;
	assign out_result.seq_length = len_q;

	// RAM address and write control
	always_comb begin
		we = 1'b0;
		waddr = {cur_q, idx_q[OffW-1:0]};
		wdata = rdata;
		raddr = {cur_q, idx_q[OffW-1:0] - OffW'(1)};
		case (state_q)
			ST_DEC: begin
				if (cmd_q == CmdQuery) begin
					raddr = {cur_q, k_q[OffW-1:0] - OffW'(1)};
				end else if (idx_q == k_q[FillW-1:0]) begin
					we = 1'b1;
					waddr = {cur_q, k_q[OffW-1:0]};
					wdata = ch_q;
				end
			end
			ST_SHWR: begin
				we = 1'b1;
			end
			ST_SPRD: begin
				raddr = {cur_q, idx_q[OffW-1:0]};
			end
			ST_SPWR: begin
				we = 1'b1;
				waddr = {fresh_q, OffW'(idx_q - keep_q)};
			end
			default: ;
		endcase
	end

	// metadata write-back: clearing pass, fill update, split
	always_comb begin
		meta_we = 1'b0;
		meta_waddr = cur_q;
		meta_wdata = {cfill_q + 1'b1, clink_q};
		case (state_q)
			ST_CLR: begin
				meta_we = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = {FillW'(0), LinkEnd};
			end
			ST_DEC: begin
				if (cmd_q == CmdInsert && idx_q == k_q[FillW-1:0]) begin
					meta_we = 1'b1;
					if (split_go)
						meta_wdata = {FillW'(BlockCap / 2), LinkW'(used_q[BlkW-1:0])};
				end
			end
			ST_SPWR: begin
				if (idx_q == FillW'(BlockCap - 1)) begin
					meta_we = 1'b1;
					meta_waddr = fresh_q;
					meta_wdata = {FillW'(BlockCap) - keep_q, clink_q};
				end
			end
			default: ;
		endcase
	end

	// Sequencer: walk the chain, shift bytes up, insert, split
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			used_q <= UsedW'(1);
			len_q <= '0;
			out_valid_q <= 1'b0;
			cur_q <= '0;
			steps_q <= '0;
		end else begin
			if (out_result.valid && out_result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BlkW'(NumBlocks - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_item.valid && in_item.ready) begin
						cmd_q <= in_item.command;
						ch_q <= in_item.character;
						cur_q <= '0;
						steps_q <= '0;
						rd_q <= '0;
						if (in_item.command == CmdInsert) begin
							k_q <= (in_item.position == '0) ? '0 : pos_m1;
							stat_q <= StatOk;
							state_q <= ST_WRD;
						end else if (in_item.position == '0 || in_item.position > len_q) begin
							stat_q <= StatRange;
							state_q <= ST_OUT;
						end else begin
							k_q <= in_item.position;
							stat_q <= StatOk;
							state_q <= ST_WRD;
						end
					end
				end
				ST_WRD: begin
					// metadata of the current block arrives
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_more) begin
						k_q <= k_q - PosW'(m_fill);
						cur_q <= m_link[BlkW-1:0];
						steps_q <= steps_q + 1'b1;
						state_q <= ST_WRD;
					end else begin
						cfill_q <= m_fill;
						clink_q <= m_link;
						if (cmd_q == CmdInsert) begin
							if (m_fill >= FillW'(BlockCap)) begin
								stat_q <= StatFull;
								state_q <= ST_OUT;
							end else begin
								if (k_q > PosW'(m_fill)) k_q <= PosW'(m_fill);
								idx_q <= m_fill;
								state_q <= ST_DEC;
							end
						end else begin
							idx_q <= '0;
							if (k_q >= PosW'(1) && k_q <= PosW'(m_fill)) begin
								state_q <= ST_DEC;
							end else begin
								stat_q <= StatRange;
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_DEC: begin
					if (cmd_q == CmdQuery) begin
						state_q <= ST_SHRD;
					end else if (idx_q > k_q[FillW-1:0]) begin
						state_q <= ST_SHWR;
					end else begin
						len_q <= len_q + 1'b1;
						if (split_go) begin
							fresh_q <= used_q[BlkW-1:0];
							keep_q <= FillW'(BlockCap / 2);
							idx_q <= FillW'(BlockCap / 2);
							state_q <= ST_SPRD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SHRD: begin
					// query read data arrives here
					rd_q <= rdata;
					state_q <= ST_OUT;
				end
				ST_SHWR: begin
					idx_q <= idx_q - 1'b1;
					state_q <= ST_DEC;
				end
				ST_SPRD: begin
					state_q <= ST_SPWR;
				end
				ST_SPWR: begin
					if (idx_q == FillW'(BlockCap - 1)) begin
						used_q <= used_q + 1'b1;
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SPRD;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLY(a_ready_idle, clk, arst_n, in_item.ready, state_q == ST_IDLE, "ready outside idle")
	`ASSERT_IMPLY(a_used_range, clk, arst_n, 1'b1, used_ok, "blocks used out of range")
	`ASSERT_NEXT(a_out_after, clk, arst_n, state_q == ST_OUT, out_valid_q, "result not posted")
endmodule

// File: hdl/bcss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bcss_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
